/* sv/jacs_pkg.sv */
// Shared types and constants for the joystick axis calibrate and scale block.
// Used by jacs_lane and the top level; depends on nothing.
`default_nettype none

package jacs_pkg;

	localparam int NumAxes  = 4;
	localparam int AxisW    = 8;
	localparam int DzW      = 7;
	localparam int DivSteps = 15;
	localparam int CntW     = $clog2(DivSteps);

	localparam logic [DzW-1:0] DzReset = 7'd7;

	typedef enum logic [1:0] {
		OP_CONVERT = 2'd0,
		OP_BEGIN   = 2'd1,
		OP_SAMPLE  = 2'd2,
		OP_END     = 2'd3
	} jacs_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} jacs_state_t;

	// Lane control, driven by the sequencer in the top level.
	typedef struct packed {
		logic load;
		logic setup;
		logic step;
	} jacs_ctrl_t;

endpackage

`default_nettype wire

/* sv/jacs_lane.sv */
// One axis lane: calibration limits, dead zone, clamp and a radix-2 divider.
// Depends on jacs_pkg.
`default_nettype none

module jacs_lane (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire jacs_pkg::jacs_ctrl_t        ctrl,
	input  wire jacs_pkg::jacs_op_t          op,
	input  wire logic                        cal,
	input  wire logic [jacs_pkg::DzW-1:0]    dead_zone,
	input  wire logic signed [jacs_pkg::AxisW-1:0] raw,
	output logic signed [jacs_pkg::AxisW-1:0] result
);
	import jacs_pkg::*;

	typedef enum logic [2:0] {
		M_ZERO,
		M_PASS,
		M_POS_SAT,
		M_NEG_SAT,
		M_POS_DIV,
		M_NEG_DIV
	} lane_mode_t;

	logic signed [AxisW-1:0] raw_q, lo_q, hi_q;
	lane_mode_t              mode_q, mode_w;
	logic [DivSteps-1:0]     num_q;
	logic [7:0]              rem_q, den_q;
	logic                    neg_q;

	logic signed [9:0]  v_w, lo_w, hi_w, dz_w, vc_w, diff_w, den_w;
	logic signed [16:0] prod_w, mag_w;
	logic               in_dz_w, pos_w;
	logic [8:0]         trial_w;
	logic               ge_w;
	logic signed [15:0] q_w, sum_w;

	// setup: everything the divider needs, from the limits before this request
	always_comb begin
		v_w     = 10'(raw_q);
		lo_w    = 10'(lo_q);
		hi_w    = 10'(hi_q);
		dz_w    = 10'(signed'({3'b000, dead_zone}));
		in_dz_w = (v_w >= -dz_w) && (v_w <= dz_w);
		if (v_w < lo_w) begin
			vc_w = lo_w;
		end else if (v_w > hi_w) begin
			vc_w = hi_w;
		end else begin
			vc_w = v_w;
		end
		pos_w  = vc_w > 10'sd0;
		diff_w = pos_w ? (vc_w - dz_w) : (vc_w - lo_w);
		den_w  = pos_w ? (hi_w - dz_w) : (-dz_w - lo_w);
		prod_w = 17'(diff_w) * 17'sd126;
		mag_w  = (prod_w < 17'sd0) ? -prod_w : prod_w;
		if (in_dz_w) begin
			mode_w = M_ZERO;
		end else if (!cal) begin
			mode_w = M_PASS;
		end else if (pos_w) begin
			mode_w = (den_w > 10'sd0) ? M_POS_DIV : M_POS_SAT;
		end else begin
			mode_w = (den_w > 10'sd0) ? M_NEG_DIV : M_NEG_SAT;
		end
	end

	// one quotient bit per step
	assign trial_w = {rem_q, num_q[DivSteps-1]};
	assign ge_w    = trial_w >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= 8'sd127;
			hi_q <= -8'sd128;
		end else if (ctrl.setup) begin
			case (op)
				OP_BEGIN: begin
					lo_q <= -8'sd1;
					hi_q <= 8'sd0;
				end
				OP_SAMPLE: begin
					if (raw_q > hi_q) hi_q <= raw_q;
					if (raw_q < lo_q) lo_q <= raw_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			raw_q <= raw;
		end
		if (ctrl.setup) begin
			mode_q <= mode_w;
			num_q  <= mag_w[DivSteps-1:0];
			den_q  <= den_w[7:0];
			neg_q  <= prod_w < 17'sd0;
			rem_q  <= '0;
		end else if (ctrl.step) begin
			rem_q <= ge_w ? 8'(trial_w - {1'b0, den_q}) : trial_w[7:0];
			num_q <= {num_q[DivSteps-2:0], ge_w};
		end
	end

	always_comb begin
		q_w = neg_q ? -signed'({1'b0, num_q}) : signed'({1'b0, num_q});
		sum_w = (mode_q == M_POS_DIV) ? (q_w + 16'sd1) : (q_w - 16'sd127);
		case (mode_q)
			M_ZERO:    result = '0;
			M_PASS:    result = raw_q;
			M_POS_SAT: result = 8'sd127;
			M_NEG_SAT: result = -8'sd127;
			M_POS_DIV: result = sum_w[AxisW-1:0];
			M_NEG_DIV: result = sum_w[AxisW-1:0];
			default:   result = '0;
		endcase
	end

endmodule

`default_nettype wire

/* sv/joystick_axis_calibrate_scale_core.sv */
// Top level of the joystick axis calibrate and scale block: sequencer, four
// axis lanes and the result register. Depends on jacs_pkg and jacs_lane.
//
// Each request carries four signed stick axes and an op code (convert, begin
// calibration, calibration sample, end calibration) and yields exactly one
// result: the four converted axes and the calibrated flag, both taken from
// the state as it stood before the request. The op then updates the stored
// per-axis limits or the calibrated flag. An axis inside +/- dead_zone reads
// 0; once calibrated, the rest is clamped to its limits and scaled onto
// 1..127 or -127..-2 by a restoring divider, one quotient bit per cycle.
// All four lanes run in lockstep. A request passes through a setup state,
// the divider steps and a done state in which the result is registered
// once the output register is free. in_ready is high only while idle, so
// a new request is taken only after the previous one has left the lanes.
// in_ready returns with the sequencer, so a new request is taken while the
// previous result still waits on the output. dead_zone resets to 7 and is
// written through the cfg channel, which is always ready.
`default_nettype none

module joystick_axis_calibrate_scale_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [jacs_pkg::DzW-1:0]           cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         op,
	input  wire logic signed [jacs_pkg::AxisW-1:0]  axis_x,
	input  wire logic signed [jacs_pkg::AxisW-1:0]  axis_y,
	input  wire logic signed [jacs_pkg::AxisW-1:0]  axis_rx,
	input  wire logic signed [jacs_pkg::AxisW-1:0]  axis_ry,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [jacs_pkg::AxisW-1:0]       out_x,
	output logic signed [jacs_pkg::AxisW-1:0]       out_y,
	output logic signed [jacs_pkg::AxisW-1:0]       out_rx,
	output logic signed [jacs_pkg::AxisW-1:0]       out_ry,
	output logic                                    is_calibrated
);
	import jacs_pkg::*;

	jacs_state_t state_q, state_nx;
	logic [CntW-1:0] cnt_q;
	jacs_op_t        op_q;
	logic            cal_done_q;
	logic            cal_snap_q;
	logic [DzW-1:0]  dead_zone_q;
	logic            out_valid_q;
	logic            out_free_w;
	logic            in_fire_w;
	logic            last_step_w;
	jacs_ctrl_t      ctrl_w;

	logic signed [AxisW-1:0] raw_w [NumAxes];
	logic signed [AxisW-1:0] res_w [NumAxes];
	logic signed [AxisW-1:0] out_q [NumAxes];

	assign cfg_ready   = 1'b1;
	assign in_fire_w   = in_valid && in_ready;
	assign out_free_w  = !out_valid_q || out_ready;
	assign last_step_w = cnt_q == CntW'(DivSteps - 1);

	assign raw_w[0] = axis_x;
	assign raw_w[1] = axis_y;
	assign raw_w[2] = axis_rx;
	assign raw_w[3] = axis_ry;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_SETUP;
			ST_SETUP: state_nx = ST_DIV;
			ST_DIV:   if (last_step_w) state_nx = ST_DONE;
			ST_DONE:  if (out_free_w) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready     = 1'b0;
		ctrl_w.load  = 1'b0;
		ctrl_w.setup = 1'b0;
		ctrl_w.step  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctrl_w.load = in_valid;
			end
			ST_SETUP: ctrl_w.setup = 1'b1;
			ST_DIV:   ctrl_w.step  = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cal_done_q  <= 1'b0;
			dead_zone_q <= DzReset;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// hold the dead zone until a config write arrives
			if (cfg_valid && cfg_ready) dead_zone_q <= cfg_data;
			// advance the divider step count
			if (ctrl_w.setup) begin
				cnt_q <= '0;
			end else if (ctrl_w.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// end of calibration latches after the conversion has seen the old flag
			if (ctrl_w.setup && op_q == OP_END) cal_done_q <= 1'b1;
			// drop the result once taken, raise a new one when the lanes finish
			if (state_q == ST_DONE && out_free_w) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire_w) op_q <= jacs_op_t'(op);
		if (ctrl_w.setup) cal_snap_q <= cal_done_q;
		if (state_q == ST_DONE && out_free_w) begin
			for (int i = 0; i < NumAxes; i++) begin
				out_q[i] <= res_w[i];
			end
		end
	end

	// merge: registered calibrated flag of the result, from the state before its request
	logic cal_out_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free_w) cal_out_q <= cal_snap_q;
	end

	for (genvar g = 0; g < NumAxes; g++) begin : g_lane
		jacs_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl_w),
			.op        (op_q),
			.cal       (cal_done_q),
			.dead_zone (dead_zone_q),
			.raw       (raw_w[g]),
			.result    (res_w[g])
		);
	end

	assign out_valid     = out_valid_q;
	assign out_x         = out_q[0];
	assign out_y         = out_q[1];
	assign out_rx        = out_q[2];
	assign out_ry        = out_q[3];
	assign is_calibrated = cal_out_q;

endmodule

`default_nettype wire

/* sim/tb_joystick_axis_calibrate_scale_core.sv */
// Self-checking testbench for joystick_axis_calibrate_scale_core: directed and random stick
// requests, dead-zone settings and calibration sessions, checked against a behavioral predictor.
// Depends on jacs_pkg and the RTL of the core; reads no files.

module tb_joystick_axis_calibrate_scale_core;
	timeunit 1ns;
	timeprecision 1ps;

	import jacs_pkg::*;

	localparam int CycleLimit = 500000;
	localparam int HoldCycles = 400;
	localparam int TailCycles = 40;
	localparam int PhaseReqs  = 190;
	localparam int NumPhases  = 9;
	localparam int MaxReports = 10;
	// Saturated outputs of the linear map.
	localparam logic [7:0] SatPos = 8'sd127;
	localparam logic [7:0] SatNeg = -8'sd127;

	// One stick request and the result it should produce; lane 0..3 = x, y, rx, ry.
	typedef struct packed {
		jacs_op_t        op;
		logic [3:0][7:0] ax;
		logic            drain;
	} stick_req_t;

	typedef struct packed {
		logic [3:0][7:0] ax;
		logic            cal;
	} stick_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_CONVERT;
	logic signed [7:0] axis_x = '0;
	logic signed [7:0] axis_y = '0;
	logic signed [7:0] axis_rx = '0;
	logic signed [7:0] axis_ry = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic signed [7:0] out_x;
	logic signed [7:0] out_y;
	logic signed [7:0] out_rx;
	logic signed [7:0] out_ry;
	logic        is_calibrated;

	joystick_axis_calibrate_scale_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.axis_x        (axis_x),
		.axis_y        (axis_y),
		.axis_rx       (axis_rx),
		.axis_ry       (axis_ry),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_rx        (out_rx),
		.out_ry        (out_ry),
		.is_calibrated (is_calibrated)
	);

	always #5ns clk = ~clk;

	// Predictor state: per-axis calibration limits, calibrated flag and dead zone.
	logic signed [7:0] lim_lo [4];
	logic signed [7:0] lim_hi [4];
	logic              cal_flag = 1'b0;
	logic [6:0]        dz_cur = DzReset;

	initial begin
		for (int i = 0; i < 4; i++) begin
			lim_lo[i] = 8'sd127;
			lim_hi[i] = -8'sd128;
		end
	end

	stick_req_t stick_reqs_todo [$];   // filled by the stimulus, drained by the driver
	stick_res_t scaled_axes_due [$];   // one entry per accepted request, oldest first
	stick_req_t cur_req;
	logic       req_fire;
	int         reqs_taken = 0;
	int         results_seen = 0;
	int         mismatches = 0;
	int         cycles = 0;
	int         src_idle = 16;
	int         dst_idle = 76;
	int         stall_asks = 0;
	int         stall_seen = 0;
	int         stall_left = 0;

	// Convert one axis: dead zone, then clamp and linear map once calibrated.
	function automatic logic [7:0] scale_axis(int v, int lo, int hi, int dz, logic cal);
		int den;
		int r;
		if (v >= -dz && v <= dz)
			return 8'd0;
		if (!cal)
			return v[7:0];
		if (v < lo)
			v = lo;
		else if (v > hi)
			v = hi;
		if (v > 0) begin
			den = hi - dz;
			if (den <= 0)
				return SatPos;
			r = (v - dz) * 126 / den + 1;
		end else begin
			// anything clamped to zero or below takes the negative map
			den = -dz - lo;
			if (den <= 0)
				return SatNeg;
			r = (v - lo) * 126 / den - 127;
		end
		return r[7:0];
	endfunction

	// Work out the result of one request from the state before it, then apply its op.
	function automatic stick_res_t predict_scaled_axes(stick_req_t rq);
		stick_res_t res;
		int v;
		for (int i = 0; i < 4; i++) begin
			v = $signed(rq.ax[i]);
			res.ax[i] = scale_axis(v, lim_lo[i], lim_hi[i], dz_cur, cal_flag);
		end
		res.cal = cal_flag;
		case (rq.op)
			OP_BEGIN: begin
				for (int i = 0; i < 4; i++) begin
					lim_lo[i] = -8'sd1;
					lim_hi[i] = 8'sd0;
				end
			end
			OP_SAMPLE: begin
				for (int i = 0; i < 4; i++) begin
					v = $signed(rq.ax[i]);
					if (v > lim_hi[i])
						lim_hi[i] = rq.ax[i];
					if (v < lim_lo[i])
						lim_lo[i] = rq.ax[i];
				end
			end
			OP_END: cal_flag = 1'b1;
			default: ;
		endcase
		return res;
	endfunction

	// Request driver: predict on acceptance, then present the next pending request
	// unless the sender idles this cycle or the request asks to wait for a full drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op       <= OP_CONVERT;
			axis_x   <= '0;
			axis_y   <= '0;
			axis_rx  <= '0;
			axis_ry  <= '0;
		end else begin
			req_fire = in_valid && in_ready;
			if (req_fire) begin
				scaled_axes_due.push_back(predict_scaled_axes(cur_req));
				reqs_taken <= reqs_taken + 1;
			end
			// hold valid and payload until the request is taken
			if (req_fire || !in_valid) begin
				if (stick_reqs_todo.size() != 0
				    && !(stick_reqs_todo[0].drain && reqs_taken + req_fire != results_seen)
				    && $urandom_range(99) >= src_idle) begin
					cur_req = stick_reqs_todo.pop_front();
					in_valid <= 1'b1;
					op       <= cur_req.op;
					axis_x   <= cur_req.ax[0];
					axis_y   <= cur_req.ax[1];
					axis_rx  <= cur_req.ax[2];
					axis_ry  <= cur_req.ax[3];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			stall_seen <= 0;
		end else if (stall_seen != stall_asks) begin
			stall_left <= HoldCycles;
			stall_seen <= stall_asks;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MaxReports)
				$display("mismatch on %s, result %0d: expected %0d, got %0d",
				         name, results_seen, $signed(want), $signed(got));
		end
	endtask

	// Result monitor: compare every accepted result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		stick_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_seen == reqs_taken) begin
					mismatches++;
					if (mismatches <= MaxReports)
						$display("result with no request outstanding: %0d %0d %0d %0d cal %0d",
						         out_x, out_y, out_rx, out_ry, is_calibrated);
				end else begin
					want = scaled_axes_due.pop_front();
					check_field("out_x", want.ax[0], out_x);
					check_field("out_y", want.ax[1], out_y);
					check_field("out_rx", want.ax[2], out_rx);
					check_field("out_ry", want.ax[3], out_ry);
					check_field("is_calibrated", {7'd0, want.cal}, {7'd0, is_calibrated});
					results_seen <= results_seen + 1;
				end
			end
			out_ready <= (stall_left == 0) && ($urandom_range(99) >= dst_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_req(input jacs_op_t o, input int x, input int y, input int rx,
	                       input int ry, input logic drain);
		stick_req_t rq;
		rq.op    = o;
		rq.ax[0] = x[7:0];
		rq.ax[1] = y[7:0];
		rq.ax[2] = rx[7:0];
		rq.ax[3] = ry[7:0];
		rq.drain = drain;
		stick_reqs_todo.push_back(rq);
	endtask

	// Mostly full-range readings, a quarter right at the dead-zone edge.
	function automatic int rand_axis();
		int m;
		if ($urandom_range(3) == 0) begin
			m = int'(dz_cur) + int'($urandom_range(2)) - 1;
			if (m < 0)
				m = 0;
			if (m > 127)
				m = 127;
			return $urandom_range(1) ? m : -m;
		end
		return $signed(8'($urandom_range(255)));
	endfunction

	task automatic add_rand(input jacs_op_t o);
		add_req(o, rand_axis(), rand_axis(), rand_axis(), rand_axis(), $urandom_range(99) == 0);
	endtask

	// Random traffic: calibration sessions followed by conversions, plain
	// conversion runs, and some noise with any op in any order.
	task automatic fill_random(input int n);
		int cnt;
		int r;
		int k;
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(99);
			if (r < 55) begin
				add_rand(OP_BEGIN);
				k = $urandom_range(10, 1);
				repeat (k) add_rand(OP_SAMPLE);
				add_rand(OP_END);
				cnt += k + 2;
				k = $urandom_range(15, 3);
				repeat (k) add_rand(OP_CONVERT);
				cnt += k;
			end else if (r < 80) begin
				k = $urandom_range(12, 4);
				repeat (k) add_rand(OP_CONVERT);
				cnt += k;
			end else begin
				k = $urandom_range(4, 1);
				repeat (k) add_rand(jacs_op_t'($urandom_range(3)));
				cnt += k;
			end
		end
	endtask

	// Wait until nothing is pending or outstanding; returns at a falling edge.
	task automatic drain();
		do
			@(negedge clk);
		while (stick_reqs_todo.size() != 0 || in_valid || reqs_taken != results_seen);
	endtask

	// Write the dead zone while the block is idle.
	task automatic write_dead_zone(input logic [6:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		dz_cur = v;
	endtask

	initial begin
		int dz_plan [NumPhases] = '{0, 126, -1, 1, 63, -1, 126, 7, -1};
		int dz_next;

		// Directed requests at the reset dead zone of 7.
		// Raw pass-through and the dead-zone edges before any calibration.
		add_req(OP_CONVERT, -128, 127, 0, -1, 1'b0);
		add_req(OP_CONVERT, 7, -7, 8, -8, 1'b0);
		// End calibration straight from reset: limits stay crossed (min above max).
		add_req(OP_END, 0, 0, 0, 0, 1'b0);
		add_req(OP_CONVERT, 50, -50, 127, -128, 1'b0);
		// Sample without begin: x and y end up with limits 1..8, so clamping a
		// negative reading up to 1 drives the map out of 8 bits.
		add_req(OP_SAMPLE, 1, 1, -128, 127, 1'b0);
		add_req(OP_SAMPLE, 8, 8, -128, 127, 1'b0);
		add_req(OP_CONVERT, -100, -128, -128, 127, 1'b0);
		// Begin waits for a full drain; limits become -1..0, divisors go non-positive.
		add_req(OP_BEGIN, 127, -128, -1, 0, 1'b1);
		add_req(OP_CONVERT, 20, -20, 127, -128, 1'b0);
		add_req(OP_SAMPLE, 127, -128, 64, -64, 1'b0);
		add_req(OP_SAMPLE, -128, 127, -64, 64, 1'b0);
		add_req(OP_SAMPLE, 3, -3, 0, 5, 1'b0);
		add_req(OP_CONVERT, 127, -128, 8, -8, 1'b0);
		add_req(OP_CONVERT, 100, -100, 64, -64, 1'b0);
		add_req(OP_CONVERT, -8, 8, -65, 65, 1'b0);
		add_req(OP_END, 85, -86, 42, -43, 1'b0);
		add_req(OP_CONVERT, 6, -6, 0, 1, 1'b0);

		// Release reset on a rising edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		for (int ph = 0; ph < NumPhases; ph++) begin
			// Sender light and receiver heavy, then swapped, then no idling at all.
			case (ph / 3)
				0: begin
					src_idle = 16;
					dst_idle = 76;
				end
				1: begin
					src_idle = 76;
					dst_idle = 16;
				end
				default: begin
					src_idle = 0;
					dst_idle = 0;
				end
			endcase
			dz_next = (dz_plan[ph] < 0) ? int'($urandom_range(126)) : dz_plan[ph];
			write_dead_zone(dz_next[6:0]);
			@(negedge clk);
			// Block the receiver for a long stretch so the core backs up its input.
			if (ph == 1 || ph == 7)
				stall_asks++;
			fill_random(PhaseReqs);
			drain();
		end

		repeat (TailCycles) @(posedge clk);
		@(negedge clk);
		mismatches += scaled_axes_due.size();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
